[src/bgi_pkg.sv]
package bgi_pkg;

  localparam int AXIS1_MAX = 32;
  localparam int AXIS2_MAX = 32;
  localparam int AX_MAX    = (AXIS1_MAX > AXIS2_MAX) ? AXIS1_MAX : AXIS2_MAX;

  localparam int AX1_AW     = $clog2(AXIS1_MAX);
  localparam int AX2_AW     = $clog2(AXIS2_MAX);
  localparam int GRID_DEPTH = AXIS1_MAX * AXIS2_MAX;
  localparam int GRID_AW    = $clog2(GRID_DEPTH);
  localparam int KW         = $clog2(AX_MAX + 1);

  localparam int IDX_W   = 5;
  localparam int CNT_W   = 6;
  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 17;
  localparam int OPER_W  = 33;
  localparam int PROD_W  = FRAC_W + 1 + OPER_W;
  localparam int SPLIT   = 25;
  localparam int ROW_W   = 50;
  localparam int ACC_W   = 66;
  localparam int STEP_W  = $clog2(FRAC_W);

  localparam logic CFG_AXIS1_COUNT = 1'b0;
  localparam logic CFG_AXIS2_COUNT = 1'b1;

  typedef enum logic [1:0] {
    REQ_AXIS1 = 2'd0,
    REQ_AXIS2 = 2'd1,
    REQ_GRID  = 2'd2,
    REQ_QUERY = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH_START,
    S_SEARCH,
    S_DIVIDE,
    S_FETCH,
    S_BLEND,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic clear;
    logic shift_hi;
  } mac_ctrl_t;

  function automatic logic [KW-1:0] clamp_count(logic [CNT_W-1:0] c, int mx);
    logic [KW-1:0] r;
    if (int'(c) < 2) begin
      r = KW'(2);
    end else if (int'(c) > mx) begin
      r = KW'(mx);
    end else begin
      r = KW'(c);
    end
    return r;
  endfunction

endpackage

[src/bgi_ram.sv]
module bgi_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/bgi_div.sv]
module bgi_div
  import bgi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] num_i,
  input  logic [DATA_W-1:0] den_i,
  output logic              done_o,
  output logic [FRAC_W-1:0] quot_o
);

  logic              run_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DATA_W+1:0] rem_q, rem_d, shifted;
  logic [DATA_W-1:0] den_q;
  logic [FRAC_W-1:0] quot_q, quot_d;
  logic              ge;

  // The numerator never exceeds the denominator, so the first quotient
  // bit is taken without a shift.
  always_comb begin
    shifted = (step_q == '0) ? rem_q : {rem_q[DATA_W:0], 1'b0};
    ge      = shifted >= {2'b00, den_q};
    rem_d   = ge ? (shifted - {2'b00, den_q}) : shifted;
    quot_d  = {quot_q[FRAC_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        if (step_q == STEP_W'(FRAC_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {2'b00, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (run_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[src/bgi_mac.sv]
module bgi_mac
  import bgi_pkg::*;
(
  input  logic                     clk_i,
  input  mac_ctrl_t                ctrl_i,
  input  logic [FRAC_W-1:0]        weight_i,
  input  logic signed [OPER_W-1:0] oper_i,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, addend, ext;

  always_comb begin
    ext    = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    addend = ctrl_i.shift_hi ? (ext <<< SPLIT) : ext;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= $signed({1'b0, weight_i}) * oper_i;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= (ctrl_i.clear ? '0 : acc_q) + addend;
    end
  end

  assign acc_o = acc_q;

endmodule

[src/bilinear_grid_interpolator_unit.sv]
// A load gives no result; busy stays low.
// A query holds busy for a span that grows with n1 and n2, the intervals
// tested on each axis; the serial axis scan and the bit-serial divider
// set it. done_o rises in the same cycle that busy falls.
// The result strobe done_o is high for one cycle; the receiver cannot stall.
// Reset clears control state and sets both counts to 32; stores are
// undefined until written.
module bilinear_grid_interpolator_unit
  import bgi_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [CNT_W-1:0]         cfg_data_i,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type_i,
  input  logic [IDX_W-1:0]         row_index_i,
  input  logic [IDX_W-1:0]         col_index_i,
  input  logic signed [DATA_W-1:0] load_value_i,
  input  logic signed [DATA_W-1:0] query_x_i,
  input  logic signed [DATA_W-1:0] query_y_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] interp_value_o,
  output logic                     out_of_range_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt1_q, cnt2_q;
  logic             ax_q, oor_q, ph_q, done_q;
  logic [KW-1:0]    k_q, cnt_eff;
  logic [2:0]       f_q, m_q;
  logic signed [DATA_W-1:0] lo_q, x_q, y_q, cur, coord, value_q;
  logic [AX1_AW-1:0] idx1_q, row_sel;
  logic [AX2_AW-1:0] idx2_q, col_sel;
  logic [FRAC_W-1:0] u_q, v_q, weight, quot;
  logic signed [DATA_W-1:0] g_q [4];
  logic signed [ROW_W-1:0]  r0_q, r1_q;
  logic signed [OPER_W-1:0] oper;
  logic signed [ACC_W-1:0]  acc, rnd;
  logic signed [DATA_W+1:0] rs;
  logic [DATA_W-1:0] sat;
  logic signed [DATA_W:0] den33, num33;
  logic hit, den_zero, div_start, div_done, accept, last_pt;
  logic [DATA_W-1:0] ax1_rdata, ax2_rdata, grid_rdata;
  logic [AX1_AW-1:0] ax1_raddr;
  logic [AX2_AW-1:0] ax2_raddr;
  logic [GRID_AW-1:0] grid_raddr, grid_waddr;
  logic ax1_we, ax2_we, grid_we;
  mac_ctrl_t mac_ctrl;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  assign ax1_we  = accept && req_e'(req_type_i) == REQ_AXIS1 && int'(row_index_i) < AXIS1_MAX;
  assign ax2_we  = accept && req_e'(req_type_i) == REQ_AXIS2 && int'(col_index_i) < AXIS2_MAX;
  assign grid_we = accept && req_e'(req_type_i) == REQ_GRID &&
                   int'(row_index_i) < AXIS1_MAX && int'(col_index_i) < AXIS2_MAX;
  assign grid_waddr = GRID_AW'(int'(row_index_i) * AXIS2_MAX + int'(col_index_i));

  bgi_ram #(.Width(DATA_W), .Depth(AXIS1_MAX)) u_axis1_ram (
    .clk_i, .we_i(ax1_we), .waddr_i(AX1_AW'(row_index_i)), .wdata_i(load_value_i),
    .raddr_i(ax1_raddr), .rdata_o(ax1_rdata)
  );

  bgi_ram #(.Width(DATA_W), .Depth(AXIS2_MAX)) u_axis2_ram (
    .clk_i, .we_i(ax2_we), .waddr_i(AX2_AW'(col_index_i)), .wdata_i(load_value_i),
    .raddr_i(ax2_raddr), .rdata_o(ax2_rdata)
  );

  bgi_ram #(.Width(DATA_W), .Depth(GRID_DEPTH)) u_grid_ram (
    .clk_i, .we_i(grid_we), .waddr_i(grid_waddr), .wdata_i(load_value_i),
    .raddr_i(grid_raddr), .rdata_o(grid_rdata)
  );

  // Interval test: the read data is point k-1 and lo_q holds point k-2.
  always_comb begin
    cur      = ax_q ? $signed(ax2_rdata) : $signed(ax1_rdata);
    coord    = ax_q ? y_q : x_q;
    cnt_eff  = ax_q ? clamp_count(cnt2_q, AXIS2_MAX) : clamp_count(cnt1_q, AXIS1_MAX);
    hit      = (coord >= lo_q) && (coord <= cur);
    den33    = {cur[DATA_W-1], cur} - {lo_q[DATA_W-1], lo_q};
    num33    = {coord[DATA_W-1], coord} - {lo_q[DATA_W-1], lo_q};
    den_zero = (den33 == '0);
    last_pt  = (k_q == cnt_eff);
    div_start = (state_q == S_SEARCH) && (k_q != KW'(1)) && hit && !den_zero;
  end

  bgi_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i(num33[DATA_W-1:0]), .den_i(den33[DATA_W-1:0]),
    .done_o(div_done), .quot_o(quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && req_e'(req_type_i) == REQ_QUERY) state_d = S_SEARCH_START;
      end
      S_SEARCH_START: state_d = S_SEARCH;
      S_SEARCH: begin
        if (k_q != KW'(1)) begin
          if (hit) begin
            state_d = den_zero ? S_FINISH : S_DIVIDE;
          end else if (last_pt) begin
            state_d = S_FINISH;
          end
        end
      end
      S_DIVIDE: begin
        if (div_done) state_d = ax_q ? S_FETCH : S_SEARCH_START;
      end
      S_FETCH: begin
        if (f_q == 3'd4) state_d = S_BLEND;
      end
      S_BLEND: begin
        if (m_q == 3'd7 && ph_q) state_d = S_FINISH;
      end
      S_FINISH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ax1_raddr = (state_q == S_SEARCH_START) ? '0 : AX1_AW'(k_q);
    ax2_raddr = (state_q == S_SEARCH_START) ? '0 : AX2_AW'(k_q);
    row_sel   = f_q[1] ? (idx1_q + AX1_AW'(1)) : idx1_q;
    col_sel   = f_q[0] ? (idx2_q + AX2_AW'(1)) : idx2_q;
    grid_raddr = GRID_AW'(int'(row_sel) * AXIS2_MAX + int'(col_sel));

    mac_ctrl.mul_en   = (state_q == S_BLEND) && !ph_q;
    mac_ctrl.acc_en   = (state_q == S_BLEND) && ph_q;
    mac_ctrl.clear    = (m_q == 3'd0) || (m_q == 3'd2) || (m_q == 3'd4);
    mac_ctrl.shift_hi = (m_q == 3'd5) || (m_q == 3'd7);

    // Row blends first, then the two rows are blended along the first axis.
    case (m_q)
      3'd0: begin weight = FRAC_W'(1 << 16) - v_q; oper = OPER_W'(g_q[0]); end
      3'd1: begin weight = v_q; oper = OPER_W'(g_q[1]); end
      3'd2: begin weight = FRAC_W'(1 << 16) - v_q; oper = OPER_W'(g_q[2]); end
      3'd3: begin weight = v_q; oper = OPER_W'(g_q[3]); end
      3'd4: begin
        weight = FRAC_W'(1 << 16) - u_q;
        oper = $signed({{(OPER_W - SPLIT){1'b0}}, r0_q[SPLIT-1:0]});
      end
      3'd5: begin
        weight = FRAC_W'(1 << 16) - u_q;
        oper = OPER_W'($signed(r0_q[ROW_W-1:SPLIT]));
      end
      3'd6: begin
        weight = u_q;
        oper = $signed({{(OPER_W - SPLIT){1'b0}}, r1_q[SPLIT-1:0]});
      end
      default: begin
        weight = u_q;
        oper = OPER_W'($signed(r1_q[ROW_W-1:SPLIT]));
      end
    endcase

    rnd = acc + (ACC_W'(1) <<< 31);
    rs  = rnd[DATA_W+33:32];
    if (rs[DATA_W+1:DATA_W-1] == 3'b000 || rs[DATA_W+1:DATA_W-1] == 3'b111) begin
      sat = rs[DATA_W-1:0];
    end else begin
      sat = rs[DATA_W+1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  bgi_mac u_mac (
    .clk_i, .ctrl_i(mac_ctrl), .weight_i(weight), .oper_i(oper), .acc_o(acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt1_q  <= CNT_W'(32);
      cnt2_q  <= CNT_W'(32);
      ax_q    <= 1'b0;
      oor_q   <= 1'b0;
      k_q     <= '0;
      f_q     <= '0;
      m_q     <= '0;
      ph_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FINISH);
      if (cfg_we_i && cfg_idx_i == CFG_AXIS1_COUNT) cnt1_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_AXIS2_COUNT) cnt2_q <= cfg_data_i;
      unique case (state_q)
        S_IDLE: begin
          ax_q  <= 1'b0;
          oor_q <= 1'b0;
        end
        S_SEARCH_START: k_q <= KW'(1);
        S_SEARCH: begin
          if (k_q == KW'(1)) begin
            k_q <= KW'(2);
          end else if (hit) begin
            oor_q <= den_zero;
          end else if (last_pt) begin
            oor_q <= 1'b1;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        S_DIVIDE: begin
          if (div_done) ax_q <= 1'b1;
          f_q <= '0;
        end
        S_FETCH: begin
          f_q  <= f_q + 3'd1;
          m_q  <= '0;
          ph_q <= 1'b0;
        end
        S_BLEND: begin
          ph_q <= !ph_q;
          if (ph_q) m_q <= m_q + 3'd1;
        end
        S_FINISH: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= query_x_i;
      y_q <= query_y_i;
    end
    if (state_q == S_SEARCH && (k_q == KW'(1) || !hit)) lo_q <= cur;
    if (div_start) begin
      if (ax_q) idx2_q <= AX2_AW'(k_q - KW'(2));
      else      idx1_q <= AX1_AW'(k_q - KW'(2));
    end
    if (state_q == S_DIVIDE && div_done) begin
      if (ax_q) v_q <= quot;
      else      u_q <= quot;
    end
    if (state_q == S_FETCH && f_q != 3'd0) g_q[2'(f_q - 3'd1)] <= $signed(grid_rdata);
    if (state_q == S_BLEND && !ph_q && m_q == 3'd2) r0_q <= acc[ROW_W-1:0];
    if (state_q == S_BLEND && !ph_q && m_q == 3'd4) r1_q <= acc[ROW_W-1:0];
    if (state_q == S_FINISH) value_q <= oor_q ? '0 : $signed(sat);
    if (state_q == S_FINISH) out_of_range_o <= oor_q;
  end

  assign done_o         = done_q;
  assign interp_value_o = value_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_range_o |-> interp_value_o == '0) else $error("flagged result not zero");
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == REQ_QUERY |=> busy) else $error("query did not start");
  a_done_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_FINISH)) else $error("stray result strobe");
  a_div_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIVIDE) else $error("divider finished outside divide");

endmodule
